// ===== hdl/isd_pkg.sv =====
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants for the image stream deframer.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int NumW   = 14;
  localparam int ByteW  = 8;
  localparam int PhaseW = 3;
  localparam int ItemW  = 3;
  localparam int TokW   = 2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_HDR     = 3'd0;
  localparam logic [PhaseW-1:0] PH_HDR_TAG = 3'd1;
  localparam logic [PhaseW-1:0] PH_LTAG    = 3'd2;
  localparam logic [PhaseW-1:0] PH_LNUM    = 3'd3;
  localparam logic [PhaseW-1:0] PH_DTAG    = 3'd4;
  localparam logic [PhaseW-1:0] PH_DATA    = 3'd5;

  localparam logic [ByteW-1:0] CH_S    = 8'h53;
  localparam logic [ByteW-1:0] CH_H    = 8'h48;
  localparam logic [ByteW-1:0] CH_W    = 8'h57;
  localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE = 8'h39;

  localparam logic [ItemW-1:0] ITEM_HEIGHT = 3'd2;
  localparam logic [ItemW-1:0] ITEM_WIDTH  = 3'd4;
  localparam logic [ItemW-1:0] ITEM_LAST   = 3'd4;
  localparam logic [TokW-1:0]  TOK_LAST    = 2'd3;

  typedef struct packed {
    logic             pixel_valid;
    logic [ByteW-1:0] pixel_byte;
    logic [NumW-1:0]  row_number;
    logic [NumW-1:0]  byte_index;
    logic             ack;
    logic             last_of_line;
    logic [NumW-1:0]  image_width;
    logic [NumW-1:0]  image_height;
    logic             bad_digit;
    logic             frame_done;
  } res_t;

endpackage

// ===== hdl/image_stream_deframer_top.sv =====
// an accepted byte waits in the input register; its result is written to the output register when it moves on
// throughput: one byte per cycle; the input stalls only while it holds a byte and
// the waiting result is held by res_stall
// bytes that complete nothing and carry no bad digit give no result item
// reset: synchronous active-high rst clears the parser state to the header
// phase and empties the input and output registers
// ----------------------------------------------------------------------------
// image_stream_deframer_top
// Input register, byte parser and output register for the image deframer.
// ----------------------------------------------------------------------------
module image_stream_deframer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_stall,
  input  logic [isd_pkg::ByteW-1:0]  rx_byte,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       pixel_valid,
  output logic [isd_pkg::ByteW-1:0]  pixel_byte,
  output logic [isd_pkg::NumW-1:0]   row_number,
  output logic [isd_pkg::NumW-1:0]   byte_index,
  output logic                       ack,
  output logic                       last_of_line,
  output logic [isd_pkg::NumW-1:0]   image_width,
  output logic [isd_pkg::NumW-1:0]   image_height,
  output logic                       bad_digit,
  output logic                       frame_done
);

  logic                      in_full;
  logic [isd_pkg::ByteW-1:0] in_byte;
  logic                      advance;
  logic                      step_hit;
  isd_pkg::res_t             step_res;
  isd_pkg::res_t             out_res;

  // the held byte moves on whenever the output register can take a result
  assign advance  = in_full && (!res_valid || !res_stall);
  assign rx_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  isd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .rx_byte (in_byte),
    .res     (step_res),
    .res_hit (step_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step_hit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_hit) begin
      out_res <= step_res;
    end
  end

  assign pixel_valid  = out_res.pixel_valid;
  assign pixel_byte   = out_res.pixel_byte;
  assign row_number   = out_res.row_number;
  assign byte_index   = out_res.byte_index;
  assign ack          = out_res.ack;
  assign last_of_line = out_res.last_of_line;
  assign image_width  = out_res.image_width;
  assign image_height = out_res.image_height;
  assign bad_digit    = out_res.bad_digit;
  assign frame_done   = out_res.frame_done;

`ifndef NO_ASSERTIONS
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (in_full && res_valid && res_stall))
    else $error("input stalled without a held byte and a held result");

  a_done_acks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_done) |-> ack)
    else $error("frame end without acknowledge");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last_of_line) |-> (pixel_valid && ack))
    else $error("end of line flagged on a non-data result");

  a_index_in_line: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pixel_valid) |-> (byte_index < image_width))
    else $error("data byte index beyond line width");
`endif

endmodule

// ===== hdl/isd_parse.sv =====
// ----------------------------------------------------------------------------
// isd_parse
// Deframing state and the per-byte update; one byte handled per enabled cycle.
// ----------------------------------------------------------------------------
module isd_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic [isd_pkg::ByteW-1:0] rx_byte,
  output isd_pkg::res_t             res,
  output logic                      res_hit
);

  logic [isd_pkg::PhaseW-1:0] phase, phase_next, phase_eff;
  logic [isd_pkg::ItemW-1:0]  header_item, header_item_next;
  logic [isd_pkg::TokW-1:0]   byte_in_token, byte_in_token_next;
  logic [isd_pkg::NumW-1:0]   number_accumulator, number_accumulator_next;
  logic [isd_pkg::NumW-1:0]   height_reg, height_reg_next;
  logic [isd_pkg::NumW-1:0]   width_reg, width_reg_next;
  logic [isd_pkg::NumW-1:0]   lines_done, lines_done_next;
  logic [isd_pkg::NumW-1:0]   current_row, current_row_next;
  logic [isd_pkg::NumW-1:0]   data_count, data_count_next;

  logic                      is_digit;
  logic [3:0]                digit;
  logic [isd_pkg::NumW-1:0]  acc_step;
  logic [isd_pkg::NumW-1:0]  lines_inc;
  logic [isd_pkg::NumW:0]    count_inc;
  logic                      pv, ack, last, bad, done;

  assign is_digit  = (rx_byte >= isd_pkg::CH_ZERO) && (rx_byte <= isd_pkg::CH_NINE);
  assign digit     = is_digit ? 4'(rx_byte - isd_pkg::CH_ZERO) : 4'd0;
  // times ten as two shifts and an add
  assign acc_step  = (number_accumulator << 3) + (number_accumulator << 1)
                     + isd_pkg::NumW'(digit);
  assign lines_inc = lines_done + isd_pkg::NumW'(1);
  assign count_inc = {1'b0, data_count} + (isd_pkg::NumW+1)'(1);
  assign phase_eff = (phase > isd_pkg::PH_DATA) ? isd_pkg::PH_HDR : phase;

  always_comb begin
    phase_next              = phase_eff;
    header_item_next        = header_item;
    byte_in_token_next      = byte_in_token;
    number_accumulator_next = number_accumulator;
    height_reg_next         = height_reg;
    width_reg_next          = width_reg;
    lines_done_next         = lines_done;
    current_row_next        = current_row;
    data_count_next         = data_count;
    pv   = 1'b0;
    ack  = 1'b0;
    last = 1'b0;
    bad  = 1'b0;
    done = 1'b0;

    case (phase_eff)
      isd_pkg::PH_HDR, isd_pkg::PH_HDR_TAG: begin
        if (phase_eff == isd_pkg::PH_HDR && byte_in_token == '0 &&
            (rx_byte == isd_pkg::CH_S || rx_byte == isd_pkg::CH_H ||
             rx_byte == isd_pkg::CH_W)) begin
          phase_next         = isd_pkg::PH_HDR_TAG;
          byte_in_token_next = isd_pkg::TokW'(1);
        end else begin
          if (phase_eff == isd_pkg::PH_HDR) begin
            bad = !is_digit;
            number_accumulator_next = acc_step;
            if (byte_in_token == isd_pkg::TOK_LAST) begin
              if (header_item == isd_pkg::ITEM_HEIGHT) height_reg_next = acc_step;
              if (header_item == isd_pkg::ITEM_WIDTH) width_reg_next = acc_step;
            end
          end
          if (byte_in_token == isd_pkg::TOK_LAST) begin
            // header item complete
            ack                     = 1'b1;
            number_accumulator_next = '0;
            byte_in_token_next      = '0;
            if (header_item >= isd_pkg::ITEM_LAST) begin
              header_item_next = '0;
              lines_done_next  = '0;
              if (height_reg_next == '0) begin
                done       = 1'b1;
                phase_next = isd_pkg::PH_HDR;
              end else begin
                phase_next = isd_pkg::PH_LTAG;
              end
            end else begin
              header_item_next = header_item + isd_pkg::ItemW'(1);
              phase_next       = isd_pkg::PH_HDR;
            end
          end else begin
            byte_in_token_next = byte_in_token + isd_pkg::TokW'(1);
          end
        end
      end
      isd_pkg::PH_LTAG: begin
        if (byte_in_token == isd_pkg::TOK_LAST) begin
          ack                     = 1'b1;
          byte_in_token_next      = '0;
          number_accumulator_next = '0;
          phase_next              = isd_pkg::PH_LNUM;
        end else begin
          byte_in_token_next = byte_in_token + isd_pkg::TokW'(1);
        end
      end
      isd_pkg::PH_LNUM: begin
        bad = !is_digit;
        number_accumulator_next = acc_step;
        if (byte_in_token == isd_pkg::TOK_LAST) begin
          current_row_next        = acc_step;
          number_accumulator_next = '0;
          byte_in_token_next      = '0;
          ack                     = 1'b1;
          phase_next              = isd_pkg::PH_DTAG;
        end else begin
          byte_in_token_next = byte_in_token + isd_pkg::TokW'(1);
        end
      end
      isd_pkg::PH_DTAG: begin
        if (byte_in_token == isd_pkg::TOK_LAST) begin
          ack                = 1'b1;
          byte_in_token_next = '0;
          data_count_next    = '0;
          if (width_reg == '0) begin
            // empty line ends on its tag
            lines_done_next = lines_inc;
            if (lines_inc >= height_reg) begin
              done             = 1'b1;
              lines_done_next  = '0;
              header_item_next = '0;
              phase_next       = isd_pkg::PH_HDR;
            end else begin
              phase_next = isd_pkg::PH_LTAG;
            end
          end else begin
            phase_next = isd_pkg::PH_DATA;
          end
        end else begin
          byte_in_token_next = byte_in_token + isd_pkg::TokW'(1);
        end
      end
      default: begin
        pv = 1'b1;
        if (count_inc >= {1'b0, width_reg}) begin
          last            = 1'b1;
          ack             = 1'b1;
          data_count_next = '0;
          lines_done_next = lines_inc;
          if (lines_inc >= height_reg) begin
            done             = 1'b1;
            lines_done_next  = '0;
            header_item_next = '0;
            phase_next       = isd_pkg::PH_HDR;
          end else begin
            phase_next = isd_pkg::PH_LTAG;
          end
        end else begin
          data_count_next = count_inc[isd_pkg::NumW-1:0];
        end
      end
    endcase

    res.pixel_valid  = pv;
    res.pixel_byte   = pv ? rx_byte : '0;
    res.row_number   = current_row_next;
    res.byte_index   = pv ? data_count : '0;
    res.ack          = ack;
    res.last_of_line = last;
    res.image_width  = width_reg_next;
    res.image_height = height_reg_next;
    res.bad_digit    = bad;
    res.frame_done   = done;
    res_hit          = ack || pv || bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= isd_pkg::PH_HDR;
      header_item        <= '0;
      byte_in_token      <= '0;
      number_accumulator <= '0;
      height_reg         <= '0;
      width_reg          <= '0;
      lines_done         <= '0;
      current_row        <= '0;
      data_count         <= '0;
    end else if (step_en) begin
      phase              <= phase_next;
      header_item        <= header_item_next;
      byte_in_token      <= byte_in_token_next;
      number_accumulator <= number_accumulator_next;
      height_reg         <= height_reg_next;
      width_reg          <= width_reg_next;
      lines_done         <= lines_done_next;
      current_row        <= current_row_next;
      data_count         <= data_count_next;
    end
  end

endmodule
